@@ design/doeq_pkg.sv @@
// Shared types and codes for the deadline-ordered expiry queue.
package doeq_pkg;

  localparam int HANDLE_W = 5;
  localparam int FIELD_T_W = 32;

  // Operation codes of the func field.
  localparam logic [1:0] FUNC_SET    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_DRAIN  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_ABSENT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INSERT,
    ST_RESP,
    ST_POP
  } state_t;

  typedef enum logic [1:0] {
    OSEL_RESP,
    OSEL_POP,
    OSEL_EMPTY
  } out_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     do_remove;
    logic     do_insert;
    logic     do_pop;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] func;
    logic       out_free;
    logic       head_due;
    logic       next_due;
  } sts_t;

endpackage

@@ design/deadline_ordered_expiry_queue.sv @@
// Top level of the deadline-ordered expiry queue.
//
//  channel | handshake           | payload
//  input   | in_valid, in_stall  | func, handle, deadline, now
//  output  | out_valid, out_stall| out_handle, expired, status, last
//
// Set goes through capture, take out, insert and respond; remove through capture, take out and respond.
// Tick and drain go through capture and an execute step, then give one result for each popped entry, or a
// single empty result when nothing is due.
// Reset clears all slot valid bits at once; the queue is empty after reset.
// Every cycle that loads a result waits while a stalled item sits in the output register.
// A new input item is taken only after the previous item's final result has been loaded.
module deadline_ordered_expiry_queue import doeq_pkg::*; #(
  parameter int CAPACITY  = 32,
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [31:0]         deadline,
  input  logic [31:0]         now,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HANDLE_W-1:0] out_handle,
  output logic                expired,
  output logic [1:0]          status,
  output logic                last
);

  cmd_t cmd;
  sts_t sts;

  doeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  doeq_dp #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .func       (func),
    .handle     (handle),
    .deadline   (deadline),
    .now        (now),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_handle (out_handle),
    .expired    (expired),
    .status     (status),
    .last       (last)
  );

endmodule

@@ design/doeq_ctrl.sv @@
// Controller state machine of the deadline-ordered expiry queue.
module doeq_ctrl import doeq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.out_sel   = OSEL_RESP;
    in_stall      = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.func)
          FUNC_SET: begin
            cmd.do_remove = 1'b1;
            state_next    = ST_INSERT;
          end
          FUNC_REMOVE: begin
            cmd.do_remove = 1'b1;
            state_next    = ST_RESP;
          end
          default: begin
            state_next = ST_POP;
          end
        endcase
      end
      ST_INSERT: begin
        cmd.do_insert = 1'b1;
        state_next    = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_RESP;
          state_next   = ST_IDLE;
        end
      end
      ST_POP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.head_due) begin
            cmd.out_sel = OSEL_POP;
            cmd.do_pop  = 1'b1;
            if (!sts.next_due) begin
              state_next = ST_IDLE;
            end
          end else begin
            cmd.out_sel = OSEL_EMPTY;
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/doeq_dp.sv @@
// Datapath of the deadline-ordered expiry queue: sorted slot chain and output register.
module doeq_dp import doeq_pkg::*; #(
  parameter int CAPACITY  = 32,
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [1:0]          func,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [31:0]         deadline,
  input  logic [31:0]         now,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [HANDLE_W-1:0] out_handle,
  output logic                expired,
  output logic [1:0]          status,
  output logic                last
);

  localparam int CUT = (TIME_BITS < FIELD_T_W) ? TIME_BITS : FIELD_T_W;

  // Captured item.
  logic [1:0]           r_func;
  logic [HANDLE_W-1:0]  r_handle;
  logic [TIME_BITS-1:0] r_dl;
  logic [TIME_BITS-1:0] r_now;
  logic [1:0]           res_status;

  // Slot chain, valid entries form a prefix in queue order.
  logic [TIME_BITS-1:0] slot_deadline [CAPACITY];
  logic [HANDLE_W-1:0]  slot_handle   [CAPACITY];
  logic [CAPACITY-1:0]  slot_valid;

  logic [CAPACITY-1:0] match, from_match, later, ins_here;
  logic                found, full, drain;

  // Capture the item fields, deadlines cut to TIME_BITS.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      r_func   <= func;
      r_handle <= handle;
      r_dl     <= TIME_BITS'(deadline[CUT-1:0]);
      r_now    <= TIME_BITS'(now[CUT-1:0]);
    end
  end

  // Per-slot compares against the captured handle and deadline.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = slot_valid[i] && (slot_handle[i] == r_handle);
      later[i] = !slot_valid[i] || (slot_deadline[i] > r_dl);
    end
    from_match[0] = match[0];
    ins_here[0]   = later[0];
    for (int i = 1; i < CAPACITY; i++) begin
      from_match[i] = from_match[i-1] | match[i];
      ins_here[i]   = later[i] & ~later[i-1];
    end
  end

  assign found = |match;
  assign full  = slot_valid[CAPACITY-1];
  assign drain = (r_func == FUNC_DRAIN);

  // Slot chain update: remove and pop shift forward, insert shifts back.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      for (int i = 0; i < CAPACITY; i++) begin
        if ((cmd.do_remove && from_match[i]) || cmd.do_pop) begin
          if (i + 1 < CAPACITY) begin
            slot_valid[i]    <= slot_valid[(i+1) % CAPACITY];
            slot_deadline[i] <= slot_deadline[(i+1) % CAPACITY];
            slot_handle[i]   <= slot_handle[(i+1) % CAPACITY];
          end else begin
            slot_valid[i] <= 1'b0;
          end
        end else if (cmd.do_insert && !full) begin
          if (ins_here[i]) begin
            slot_valid[i]    <= 1'b1;
            slot_deadline[i] <= r_dl;
            slot_handle[i]   <= r_handle;
          end else if (i > 0 && later[i] && later[(i+CAPACITY-1) % CAPACITY]) begin
            slot_valid[i]    <= slot_valid[(i+CAPACITY-1) % CAPACITY];
            slot_deadline[i] <= slot_deadline[(i+CAPACITY-1) % CAPACITY];
            slot_handle[i]   <= slot_handle[(i+CAPACITY-1) % CAPACITY];
          end
        end
      end
    end
  end

  // Status of set and remove, kept until the response goes out.
  always_ff @(posedge clk) begin
    if (cmd.do_remove) begin
      res_status <= found ? STATUS_OK : STATUS_ABSENT;
    end else if (cmd.do_insert) begin
      res_status <= full ? STATUS_FULL : STATUS_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OSEL_POP: begin
          out_handle <= slot_handle[0];
          expired    <= 1'b1;
          status     <= STATUS_OK;
          last       <= !sts.next_due;
        end
        OSEL_EMPTY: begin
          out_handle <= '0;
          expired    <= 1'b0;
          status     <= STATUS_OK;
          last       <= 1'b1;
        end
        default: begin
          out_handle <= r_handle;
          expired    <= 1'b0;
          status     <= res_status;
          last       <= 1'b1;
        end
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.func     = r_func;
    sts.out_free = !out_valid || !out_stall;
    sts.head_due = slot_valid[0] && (drain || slot_deadline[0] < r_now);
    sts.next_due = slot_valid[1] && (drain || slot_deadline[1] < r_now);
  end

  // Invariants of the chain.
  logic prefix_ok, sorted_ok;
  always_comb begin
    prefix_ok = 1'b1;
    sorted_ok = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      if (slot_valid[i] && !slot_valid[i-1]) prefix_ok = 1'b0;
      if (slot_valid[i] && slot_deadline[i] < slot_deadline[i-1]) sorted_ok = 1'b0;
    end
  end

  a_prefix: assert property (@(posedge clk) disable iff (rst) prefix_ok)
    else $error("valid slots do not form a prefix");
  a_sorted: assert property (@(posedge clk) disable iff (rst) sorted_ok)
    else $error("slot chain out of deadline order");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output loaded over a waiting item");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.do_pop |-> slot_valid[0])
    else $error("pop from an empty queue");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the deadline-ordered expiry queue.
`timescale 1ns / 100ps

module tb_top;
  import doeq_pkg::*;

  localparam int SLOTS = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [HANDLE_W-1:0] hnd;
    logic                exp;
    logic [1:0]          st;
    logic                lst;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FUNC_SET;
  logic [HANDLE_W-1:0] handle = '0;
  logic [31:0] deadline = '0;
  logic [31:0] now = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [HANDLE_W-1:0] out_handle;
  logic expired;
  logic [1:0] status;
  logic last;

  // Shadow copy of the sorted timer store.
  logic [31:0]         q_deadline [$];
  logic [HANDLE_W-1:0] q_handle [$];
  result_t             pending_results [$];

  int  errors = 0;
  int  idle_cycles = 0;
  int  hold_off = 0;
  bit  quiet_rx = 1'b0;

  deadline_ordered_expiry_queue uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .handle(handle), .deadline(deadline), .now(now),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_handle(out_handle), .expired(expired), .status(status), .last(last)
  );

  always #1 clk = ~clk;

  // Find the queue position of a handle, or -1.
  function automatic int find_timer(logic [HANDLE_W-1:0] h);
    foreach (q_handle[i]) begin
      if (q_handle[i] == h) return i;
    end
    return -1;
  endfunction

  // Update the shadow store for one item and queue its results.
  task automatic predict_timer_op(logic [1:0] f, logic [HANDLE_W-1:0] h,
                                  logic [31:0] dl, logic [31:0] tnow);
    int pos;
    int cnt;
    result_t r;
    pos = find_timer(h);
    cnt = 0;
    r = '0;
    case (f)
      FUNC_SET: begin
        if (pos >= 0) begin
          q_deadline.delete(pos);
          q_handle.delete(pos);
        end
        r.hnd = h;
        r.lst = 1'b1;
        if (q_handle.size() >= SLOTS) begin
          r.st = STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < q_deadline.size() && q_deadline[pos] <= dl) pos++;
          q_deadline.insert(pos, dl);
          q_handle.insert(pos, h);
          r.st = STATUS_OK;
        end
        pending_results.push_back(r);
      end
      FUNC_REMOVE: begin
        r.hnd = h;
        r.lst = 1'b1;
        if (pos < 0) begin
          r.st = STATUS_ABSENT;
        end else begin
          q_deadline.delete(pos);
          q_handle.delete(pos);
          r.st = STATUS_OK;
        end
        pending_results.push_back(r);
      end
      default: begin
        while (q_handle.size() > 0 && (f == FUNC_DRAIN || q_deadline[0] < tnow)) begin
          r.hnd = q_handle.pop_front();
          void'(q_deadline.pop_front());
          r.exp = 1'b1;
          r.st = STATUS_OK;
          r.lst = 1'b0;
          pending_results.push_back(r);
          cnt++;
        end
        if (cnt == 0) begin
          r = '0;
          r.lst = 1'b1;
          pending_results.push_back(r);
        end else begin
          pending_results[$].lst = 1'b1;
        end
      end
    endcase
  endtask

  // Offer one item and wait until it is accepted.
  task automatic send_item(logic [1:0] f, logic [HANDLE_W-1:0] h,
                           logic [31:0] dl, logic [31:0] tnow);
    func <= f;
    handle <= h;
    deadline <= dl;
    now <= tnow;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_timer_op(f, h, dl, tnow);
  endtask

  // Gap between bursts: lower valid, wait, then draw a new burst length.
  task automatic maybe_gap(ref int burst);
    if (burst > 0) begin
      burst--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst = $urandom_range(0, 12);
    end
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // Extremes of each field and every operation.
  task automatic test_directed();
    send_item(FUNC_TICK, 5'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(FUNC_DRAIN, 5'd0, 32'd0, 32'd0);
    send_item(FUNC_REMOVE, 5'd31, 32'd0, 32'd0);
    send_item(FUNC_SET, 5'd31, 32'hFFFF_FFFF, 32'd0);
    send_item(FUNC_SET, 5'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(FUNC_SET, 5'd7, 32'd100, 32'd0);
    send_item(FUNC_SET, 5'd8, 32'd100, 32'd0);
    send_item(FUNC_SET, 5'd7, 32'd100, 32'd0);
    send_item(FUNC_TICK, 5'd0, 32'd0, 32'd100);
    send_item(FUNC_TICK, 5'd0, 32'd0, 32'd101);
    send_item(FUNC_REMOVE, 5'd31, 32'd0, 32'd0);
    send_item(FUNC_REMOVE, 5'd31, 32'd0, 32'd0);
    send_item(FUNC_TICK, 5'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(FUNC_DRAIN, 5'd0, 32'd0, 32'd0);
    wait_results_done();
  endtask

  // Fill every slot, overwrite one, tick part of it out, set four more, and drain the rest in one item.
  task automatic test_full_queue();
    for (int i = 0; i < SLOTS; i++) begin
      send_item(FUNC_SET, i[HANDLE_W-1:0], $urandom_range(0, 15), 32'd0);
    end
    send_item(FUNC_SET, 5'd3, 32'hAAAA_5555, 32'd0);
    send_item(FUNC_TICK, 5'd0, 32'd0, 32'd8);
    for (int i = 0; i < 4; i++) begin
      send_item(FUNC_SET, i[HANDLE_W-1:0], 32'd5, 32'd0);
    end
    send_item(FUNC_DRAIN, 5'd0, 32'd0, 32'd0);
    wait_results_done();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    hold_off = 200;
    for (int i = 0; i < 40; i++) begin
      send_item(2'($urandom_range(0, 3)), HANDLE_W'($urandom_range(0, 31)),
                $urandom_range(0, 63), $urandom_range(0, 63));
    end
    wait_results_done();
  endtask

  // Random mix in bursts; deadlines drawn near a moving clock.
  task automatic test_random_mix();
    int burst;
    logic [31:0] base;
    logic [1:0] f;
    burst = 0;
    base = 32'd1000;
    for (int i = 0; i < 290; i++) begin
      maybe_gap(burst);
      f = ($urandom_range(0, 9) < 6) ? FUNC_SET :
          ($urandom_range(0, 2) == 0) ? FUNC_REMOVE :
          ($urandom_range(0, 7) == 0) ? FUNC_DRAIN : FUNC_TICK;
      if ($urandom_range(0, 19) == 0) base = $urandom();
      send_item(f, HANDLE_W'($urandom_range(0, 31)),
                ($urandom_range(0, 9) == 0) ? $urandom() : base + $urandom_range(0, 60),
                ($urandom_range(0, 9) == 0) ? $urandom() : base + $urandom_range(0, 40));
      base = base + $urandom_range(0, 4);
      if (i == 150) quiet_rx = 1'b1;
      if (i == 200) quiet_rx = 1'b0;
      if (i == 240) wait_results_done();
    end
    wait_results_done();
  endtask

  // Receiver stall pattern, with a forced hold-off when asked.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (quiet_rx) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result handle=%0d expired=%0b status=%0d last=%0b",
                 $time, out_handle, expired, status, last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.hnd !== out_handle) begin
          $display("%0t: out_handle expected %0d actual %0d", $time, want.hnd, out_handle);
          errors++;
        end
        if (want.exp !== expired) begin
          $display("%0t: expired expected %0b actual %0b", $time, want.exp, expired);
          errors++;
        end
        if (want.st !== status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          errors++;
        end
        if (want.lst !== last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.lst, last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results pending", $time,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_backpressure();
    test_random_mix();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/doeq_pkg.sv
design/doeq_ctrl.sv
design/doeq_dp.sv
design/deadline_ordered_expiry_queue.sv
test/tb_top.sv
